/* src/bspd_pkg.sv */
// Package: shared types and constants of the bus slave packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package bspd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_CMD     = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_DROP    = 3'd6
    } frame_phase_t;

    typedef enum logic [1:0] {
        LINK_PROBE  = 2'd0,
        LINK_ATTACH = 2'd1,
        LINK_ON     = 2'd2
    } link_phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;

    localparam logic [2:0] ACT_IGNORE  = 3'd0;
    localparam logic [2:0] ACT_PROBE   = 3'd1;
    localparam logic [2:0] ACT_ATTACH  = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_COMMAND = 3'd4;

    localparam logic [2:0] REG_DEVICE_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_SYNC_VALUE       = 3'd1;
    localparam logic [2:0] REG_MAX_PAYLOAD      = 3'd2;
    localparam logic [2:0] REG_PROBE_CODE       = 3'd3;
    localparam logic [2:0] REG_ATTACH_CODE      = 3'd4;
    localparam logic [2:0] REG_RELEASE_CODE     = 3'd5;
    localparam logic [2:0] REG_BROADCAST        = 3'd6;
    localparam logic [2:0] REG_GROUP_BROADCAST  = 3'd7;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] sync_value;
        logic [7:0] max_payload;
        logic [7:0] probe_code;
        logic [7:0] attach_code;
        logic [7:0] release_code;
        logic [7:0] broadcast_address;
        logic [7:0] group_broadcast_address;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        device_address:          8'd1,
        sync_value:              8'h55,
        max_payload:             8'd32,
        probe_code:              8'd1,
        attach_code:             8'd2,
        release_code:            8'd3,
        broadcast_address:       8'd255,
        group_broadcast_address: 8'd254
    };

    // One classified event from the framer.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] address;
        logic [7:0] command;
        logic [7:0] length;
        logic       checksum_ok;
    } event_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] packet_address;
        logic [7:0] command;
        logic [7:0] payload_length;
        logic       checksum_ok;
        logic [2:0] action;
        logic [1:0] link_state;
    } result_t;

endpackage

`default_nettype wire

/* src/bus_slave_packet_deframer_unit.sv */
// Top level: packet deframer and link machine of a bus slave.
//
// Input channel: one received bus byte per word on rx_byte, in_valid/in_stall.
// Output channel: one result word (payload byte, packet end or length error)
// on the result ports, out_valid/out_stall. Bytes that only advance the
// framer (sync hunt, header, dropped byte) produce no output word.
// Throughput: one byte per clock cycle while in_stall is low. A result is
// written by the framer into the event queue when its byte is accepted,
// then taken by the link machine into the output register once that
// register is free.
// Reset puts the framer into sync hunt, the link machine into probe wait
// and all configuration registers to their defaults.
// When the receiver stalls, the output word holds, the event queue
// (FIFO_DEPTH words) fills, and then in_stall rises until space frees up.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while no words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module bus_slave_packet_deframer_unit #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       packet_address,
    output logic [7:0]       command,
    output logic [7:0]       payload_length,
    output logic             checksum_ok,
    output logic [2:0]       action,
    output logic [1:0]       link_state
);
    import bspd_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    event_t  front_ev, queue_ev;
    logic    front_push, queue_full, queue_not_empty, queue_pop, accept;
    result_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS:  cfg_next.device_address          = cfg_data;
                REG_SYNC_VALUE:      cfg_next.sync_value              = cfg_data;
                REG_MAX_PAYLOAD:     cfg_next.max_payload             = cfg_data;
                REG_PROBE_CODE:      cfg_next.probe_code              = cfg_data;
                REG_ATTACH_CODE:     cfg_next.attach_code             = cfg_data;
                REG_RELEASE_CODE:    cfg_next.release_code            = cfg_data;
                REG_BROADCAST:       cfg_next.broadcast_address       = cfg_data;
                REG_GROUP_BROADCAST: cfg_next.group_broadcast_address = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    bspd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .rx_byte (rx_byte),
        .ev      (front_ev),
        .ev_push (front_push)
    );

    bspd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_ev),
        .pop       (queue_pop),
        .pop_data  (queue_ev),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    bspd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev        (queue_ev),
        .ev_valid  (queue_not_empty),
        .ev_pop    (queue_pop),
        .res       (res),
        .res_valid (out_valid),
        .res_stall (out_stall)
    );

    assign kind           = res.kind;
    assign payload_byte   = res.payload_byte;
    assign packet_address = res.packet_address;
    assign command        = res.command;
    assign payload_length = res.payload_length;
    assign checksum_ok    = res.checksum_ok;
    assign action         = res.action;
    assign link_state     = res.link_state;

endmodule

`default_nettype wire

/* src/bspd_front.sv */
// Framer: sync hunt, header capture, payload count and checksum check.
`timescale 1ns / 1ps
`default_nettype none

module bspd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bspd_pkg::cfg_t  cfg,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    output bspd_pkg::event_t     ev,
    output logic                 ev_push
);
    import bspd_pkg::*;

    frame_phase_t phase_reg, phase_next;
    logic [7:0]   seen_reg, seen_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   addr_reg, addr_next;
    logic [7:0]   cmd_reg, cmd_next;
    logic [7:0]   xor_reg, xor_next;
    logic [7:0]   seen_inc;

    assign seen_inc = seen_reg + 8'd1;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        xor_next   = xor_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    xor_next   = rx_byte;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte > cfg.max_payload)
                    begin
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        len_next   = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        seen_next  = 8'd0;
                        phase_next = (rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
                    end
                end
                PH_PAYLOAD:
                begin
                    xor_next  = xor_reg ^ rx_byte;
                    seen_next = seen_inc;
                    if (seen_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                end
                PH_DROP:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == cfg.sync_value)
                    begin
                        seen_next  = 8'd0;
                        xor_next   = 8'd0;
                        phase_next = PH_ADDR;
                    end
                end
            endcase
        end
    end

    // event output
    always_comb
    begin
        ev_push        = 1'b0;
        ev.kind        = KIND_PAYLOAD;
        ev.data        = 8'd0;
        ev.address     = addr_reg;
        ev.command     = cmd_reg;
        ev.length      = len_reg;
        ev.checksum_ok = 1'b0;
        case (phase_reg)
            PH_LEN:
            begin
                if (rx_byte > cfg.max_payload)
                begin
                    ev_push   = accept;
                    ev.kind   = KIND_LEN_ERR;
                    ev.length = rx_byte;
                end
            end
            PH_PAYLOAD:
            begin
                ev_push = accept;
                ev.kind = KIND_PAYLOAD;
                ev.data = rx_byte;
            end
            PH_CHECK:
            begin
                ev_push        = accept;
                ev.kind        = KIND_END;
                ev.checksum_ok = (xor_reg == rx_byte);
            end
            default:
            begin
                ev_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            seen_reg  <= 8'd0;
            len_reg   <= 8'd0;
            addr_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            xor_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            cmd_reg   <= cmd_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

`default_nettype wire

/* src/bspd_fifo.sv */
// Small event queue between framer and link machine.
`timescale 1ns / 1ps
`default_nettype none

module bspd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bspd_pkg::event_t  push_data,
    input  wire logic              pop,
    output bspd_pkg::event_t       pop_data,
    output logic                   not_empty,
    output logic                   full
);
    import bspd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    event_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/bspd_back.sv */
// Link machine and output register.
`timescale 1ns / 1ps
`default_nettype none

module bspd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bspd_pkg::cfg_t    cfg,
    input  wire bspd_pkg::event_t  ev,
    input  wire logic              ev_valid,
    output logic                   ev_pop,
    output bspd_pkg::result_t      res,
    output logic                   res_valid,
    input  wire logic              res_stall
);
    import bspd_pkg::*;

    link_phase_t link_reg, link_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    logic [2:0]  action;
    logic        mine, any_addr, load;

    assign load   = !out_valid_reg || !res_stall;
    assign ev_pop = ev_valid && load;
    assign mine   = (ev.address == cfg.device_address);
    assign any_addr = mine || (ev.address == cfg.broadcast_address)
                    || (ev.address == cfg.group_broadcast_address);

    // next link state
    always_comb
    begin
        link_next = link_reg;
        if (ev_pop && ev.kind == KIND_END && ev.checksum_ok)
        begin
            case (link_reg)
                LINK_ATTACH:
                begin
                    if (ev.command == cfg.attach_code && mine)
                    begin
                        link_next = LINK_ON;
                    end
                end
                LINK_ON:
                begin
                    if (any_addr && ev.command == cfg.release_code)
                    begin
                        link_next = LINK_PROBE;
                    end
                end
                default:
                begin
                    // probe wait and unused code: probe to this device -> attach, else probe wait
                    link_next = (ev.command == cfg.probe_code && mine) ?
                                LINK_ATTACH : LINK_PROBE;
                end
            endcase
        end
    end

    // action code
    always_comb
    begin
        action = ACT_IGNORE;
        if (ev.kind == KIND_END && ev.checksum_ok)
        begin
            case (link_reg)
                LINK_ATTACH:
                begin
                    if (ev.command == cfg.attach_code && mine)
                    begin
                        action = ACT_ATTACH;
                    end
                end
                LINK_ON:
                begin
                    if (any_addr)
                    begin
                        action = (ev.command == cfg.release_code) ?
                                 ACT_RELEASE : ACT_COMMAND;
                    end
                end
                default:
                begin
                    if (ev.command == cfg.probe_code && mine)
                    begin
                        action = ACT_PROBE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (load)
        begin
            out_valid_next = ev_valid;
            if (ev_valid)
            begin
                res_next.kind           = ev.kind;
                res_next.payload_byte   = ev.data;
                res_next.packet_address = ev.address;
                res_next.command        = ev.command;
                res_next.payload_length = ev.length;
                res_next.checksum_ok    = ev.checksum_ok;
                res_next.action         = action;
                res_next.link_state     = link_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg      <= LINK_PROBE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire
